// ===== hw/rtl/ntaf_pkg.sv =====
package ntaf_pkg;

    localparam logic [1:0] ACT_DEC   = 2'd0;
    localparam logic [1:0] ACT_HEX32 = 2'd1;
    localparam logic [1:0] ACT_HEX64 = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] HEX_ALPHA  = 8'h37;
    localparam logic [3:0] NIB_MASK   = 4'hF;

    localparam int DEC_DIGITS = 20;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int VALUE_W    = 64;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] value;
    } request_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        MODE_DEC,
        MODE_HEX32,
        MODE_HEX64
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        neg;
        logic [63:0] data;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREFIX_X,
        S_HEX,
        S_CONV,
        S_SKIP,
        S_DEC
    } back_state_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIB_MASK;
        if (n > 4'd9)
            hex_char = {4'd0, n} + HEX_ALPHA;
        else
            hex_char = {4'd0, n} + CHAR_ZERO;
    endfunction

endpackage

// ===== hw/rtl/number_to_ascii_formatter.sv =====
// number_to_ascii_formatter
// request channel: drive request (action, value) with start; it is taken at a
// rising edge with start high and busy low. busy is high while the job queue
// is full. action 3 is taken and produces no text.
// result channel: each character appears on result for one cycle with strobe
// high; result.last marks the final character of a number. the receiver
// cannot stall, so one character leaves per cycle while text is emitted.
// the first hex text character or the minus sign appears in the cycle after
// the job reaches the converter; decimal digits follow the conversion and skip.
// per request the converter spends a dispatch step, then for hex the rest of
// the prefix and the digits; for decimal the 64 double-dabble steps, the skip
// that drops leading zeros, then the digit outputs; the decimal conversion is
// a bit-serial double-dabble loop.
// a QUEUE_DEPTH-entry queue lets new requests be taken while one is converted.
// reset empties the queue and returns the converter to idle; nothing else
// needs clearing.
module number_to_ascii_formatter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ntaf_pkg::request_t  request,
    output logic                busy,
    output logic                strobe,
    output ntaf_pkg::result_t   result
);
    import ntaf_pkg::*;

    job_t          push_job;
    job_t          head_job;
    queue_status_t status;
    logic          push;
    logic          pop;

    ntaf_front u_front (
        .start   (start),
        .request (request),
        .status  (status),
        .busy    (busy),
        .push    (push),
        .job     (push_job)
    );

    ntaf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .status   (status)
    );

    ntaf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_job),
        .status (status),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

// ===== hw/rtl/ntaf_front.sv =====
module ntaf_front (
    input  logic                      start,
    input  ntaf_pkg::request_t        request,
    input  ntaf_pkg::queue_status_t   status,
    output logic                      busy,
    output logic                      push,
    output ntaf_pkg::job_t            job
);
    import ntaf_pkg::*;

    logic [63:0] magnitude;
    logic        valid_action;

    assign busy      = status.full;
    assign magnitude = request.value[63] ? (64'd0 - request.value) : request.value;

    always_comb
    begin
        job          = '0;
        valid_action = 1'b1;
        unique case (request.action)
            ACT_DEC:
            begin
                job.mode = MODE_DEC;
                job.neg  = request.value[63];
                job.data = magnitude;
            end
            ACT_HEX32:
            begin
                job.mode = MODE_HEX32;
                job.data = {request.value[31:0], 32'd0};
            end
            ACT_HEX64:
            begin
                job.mode = MODE_HEX64;
                job.data = request.value;
            end
            default:
            begin
                valid_action = 1'b0;
            end
        endcase
    end

    // unused action code is taken and dropped
    assign push = start && !status.full && valid_action;

endmodule

// ===== hw/rtl/ntaf_queue.sv =====
module ntaf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  ntaf_pkg::job_t            push_job,
    input  logic                      pop,
    output ntaf_pkg::job_t            head,
    output ntaf_pkg::queue_status_t   status
);
    import ntaf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== hw/rtl/ntaf_back.sv =====
module ntaf_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ntaf_pkg::job_t            head,
    input  ntaf_pkg::queue_status_t   status,
    output logic                      pop,
    output logic                      strobe,
    output ntaf_pkg::result_t         result
);
    import ntaf_pkg::*;

    back_state_t      state_reg, state_next;
    logic [63:0]      bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] bcd_adj;
    logic [5:0]       cnt_reg, cnt_next;
    logic             strobe_reg, strobe_next;
    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;

    // add-3 correction of each bcd digit before the shift
    always_comb
    begin
        for (int d = 0; d < DEC_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        pop         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!status.empty)
                begin
                    pop      = 1'b1;
                    bin_next = head.data;
                    if (head.mode == MODE_DEC)
                    begin
                        bcd_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CONV;
                        if (head.neg)
                        begin
                            strobe_next = 1'b1;
                            char_next   = CHAR_MINUS;
                        end
                    end
                    else
                    begin
                        cnt_next    = (head.mode == MODE_HEX32) ? 6'd7 : 6'd15;
                        strobe_next = 1'b1;
                        char_next   = CHAR_ZERO;
                        state_next  = S_PREFIX_X;
                    end
                end
            end
            S_PREFIX_X:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_X;
                state_next  = S_HEX;
            end
            S_HEX:
            begin
                strobe_next = 1'b1;
                char_next   = hex_char(bin_reg[63:60]);
                last_next   = (cnt_reg == '0);
                bin_next    = {bin_reg[59:0], 4'd0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_IDLE;
            end
            S_CONV:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[63]};
                bin_next = {bin_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'(VALUE_W - 1))
                begin
                    cnt_next   = 6'(DEC_DIGITS - 1);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keep the ones digit
                if (bcd_reg[BCD_W-1 -: 4] == 4'd0 && cnt_reg != '0)
                begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                strobe_next = 1'b1;
                char_next   = {4'd0, bcd_reg[BCD_W-1 -: 4]} + CHAR_ZERO;
                last_next   = (cnt_reg == '0);
                bcd_next    = {bcd_reg[BCD_W-5:0], 4'd0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        char_reg <= char_next;
    end

    assign strobe           = strobe_reg;
    assign result.character = char_reg;
    assign result.last      = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) last_reg |-> strobe_reg)
        else $error("last without strobe");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV && cnt_reg != '0) |-> !strobe_reg)
        else $error("character emitted during conversion");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEC |-> bcd_reg[BCD_W-1 -: 4] <= 4'd9)
        else $error("bcd digit out of range");

endmodule

// ===== dv/ntaf_text_checker.sv =====
module ntaf_text_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  ntaf_pkg::request_t  request,
    input  logic                strobe,
    input  ntaf_pkg::result_t   result,
    output int                  errors,
    output int                  pending,
    output int                  chars_checked
);
    import ntaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    result_t text_due[$];

    initial
    begin
        errors = 0;
        pending = 0;
        chars_checked = 0;
    end

    // expected characters of one request, last flag on the final one
    function automatic void queue_text(request_t r);
        logic [7:0]  chars[DEC_DIGITS];
        logic [7:0]  digs[DEC_DIGITS];
        logic [63:0] mag;
        logic [63:0] data;
        logic [3:0]  nib;
        int          n;
        int          nd;
        int          ndig;
        result_t     item;
        n = 0;
        nd = 0;
        ndig = 0;
        if (r.action == ACT_DEC)
        begin
            mag = r.value[63] ? 64'd0 - r.value : r.value;
            if (r.value[63])
            begin
                chars[n] = CHAR_MINUS;
                n++;
            end
            if (mag == 64'd0)
            begin
                chars[n] = CHAR_ZERO;
                n++;
            end
            while (mag != 64'd0)
            begin
                digs[nd] = CHAR_ZERO + 8'(mag % 64'd10);
                mag = mag / 64'd10;
                nd++;
            end
            while (nd > 0)
            begin
                nd--;
                chars[n] = digs[nd];
                n++;
            end
        end
        else if (r.action == ACT_HEX32 || r.action == ACT_HEX64)
        begin
            ndig = (r.action == ACT_HEX32) ? 8 : 16;
            data = (r.action == ACT_HEX32) ? {32'd0, r.value[31:0]} : r.value;
            chars[0] = CHAR_ZERO;
            chars[1] = CHAR_X;
            n = 2;
            for (int i = ndig - 1; i >= 0; i--)
            begin
                nib = data[i*4 +: 4];
                chars[n] = (nib > 4'd9) ? {4'd0, nib} + HEX_ALPHA : {4'd0, nib} + CHAR_ZERO;
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            item.character = chars[k];
            item.last = (k == n - 1);
            text_due.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t due;
        if (rst_n)
        begin
            if (start && !busy)
                queue_text(request);
            if (strobe)
            begin
                if (text_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected character %h last %b at %0t",
                                 result.character, result.last, $realtime);
                    errors <= errors + 1;
                end
                else
                begin
                    due = text_due.pop_front();
                    chars_checked <= chars_checked + 1;
                    if (result.character !== due.character || result.last !== due.last)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected %h last %b, got %h last %b at %0t",
                                     due.character, due.last, result.character,
                                     result.last, $realtime);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= text_due.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import ntaf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int NUM_ITEMS = 380;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     strobe;
    result_t  result;
    int       errors;
    int       pending;
    int       chars_checked;
    int       n_dec = 0;
    int       n_hex32 = 0;
    int       n_hex64 = 0;
    int       n_ignored = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    number_to_ascii_formatter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .strobe  (strobe),
        .result  (result)
    );

    ntaf_text_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .request       (request),
        .strobe        (strobe),
        .result        (result),
        .errors        (errors),
        .pending       (pending),
        .chars_checked (chars_checked)
    );

    task automatic send_request(input logic [1:0] action, input logic [63:0] value);
        @(negedge clk);
        start <= 1'b1;
        request <= '{action: action, value: value};
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        case (action)
            ACT_DEC:   n_dec++;
            ACT_HEX32: n_hex32++;
            ACT_HEX64: n_hex64++;
            default:   n_ignored++;
        endcase
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        request <= '{action: 2'($urandom), value: {$urandom, $urandom}};
        repeat (cycles - 1) @(negedge clk);
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] p;
        p = 64'd1;
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 999));
            2: return 64'd0 - 64'($urandom_range(1, 999));
            3:
            begin
                repeat ($urandom_range(0, 19)) p = p * 64'd10;
                p = p + 64'd0 - 64'($urandom_range(0, 2)) + 64'd1;
                return $urandom_range(0, 1) ? 64'd0 - p : p;
            end
            4: return {{32{1'b1}} & {32{$urandom_range(0, 1) == 1}}, 32'($urandom)};
            default: return {1'b1, 63'd0} + 64'($urandom_range(0, 3)) - 64'd2;
        endcase
    endfunction

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int counted;
        int burst;
        logic [1:0] action;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        idle_gap(2);

        // decimal corners
        send_request(ACT_DEC, 64'd0);
        send_request(ACT_DEC, 64'd1);
        send_request(ACT_DEC, 64'd9);
        send_request(ACT_DEC, 64'd10);
        send_request(ACT_DEC, {64{1'b1}});
        send_request(ACT_DEC, {1'b0, {63{1'b1}}});
        send_request(ACT_DEC, {1'b1, 63'd0});
        send_request(ACT_DEC, {1'b1, 62'd0, 1'b1});
        send_request(ACT_DEC, 64'd1000000000000000000);
        send_request(ACT_DEC, 64'd999999999999999999);
        idle_gap(7);
        send_request(ACT_DEC, 64'd0 - 64'd1000000000000000000);
        // hex corners
        send_request(ACT_HEX32, 64'd0);
        send_request(ACT_HEX32, {32'hFFFFFFFF, 32'h0});
        send_request(ACT_HEX32, {32'h0, 32'hFFFFFFFF});
        send_request(ACT_HEX32, 64'h89ABCDEF_01234567);
        send_request(ACT_HEX64, 64'd0);
        send_request(ACT_HEX64, {64{1'b1}});
        send_request(ACT_HEX64, 64'h01234567_89ABCDEF);
        send_request(ACT_HEX64, 64'hFEDCBA98_76543210);
        // unused action
        send_request(ACT_NONE, 64'd0);
        send_request(ACT_NONE, {64{1'b1}});
        send_request(ACT_DEC, 64'd42);
        idle_gap(3);

        counted = 0;
        while (counted < NUM_ITEMS)
        begin
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                case ($urandom_range(0, 11))
                    0: action = ACT_NONE;
                    1, 2, 3: action = ACT_HEX32;
                    4, 5, 6: action = ACT_HEX64;
                    default: action = ACT_DEC;
                endcase
                send_request(action, pick_value());
                counted++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 40));
        end
        idle_gap(1);

        wait (pending == 0);
        repeat (200) @(posedge clk);

        $display("covered %0d decimal, %0d hex32, %0d hex64 and %0d ignored requests",
                 n_dec, n_hex32, n_hex64, n_ignored);
        $display("checked %0d characters, %0d mismatches, %0d still due",
                 chars_checked, errors, pending);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ntaf_pkg.sv
hw/rtl/ntaf_front.sv
hw/rtl/ntaf_queue.sv
hw/rtl/ntaf_back.sv
hw/rtl/number_to_ascii_formatter.sv
dv/ntaf_text_checker.sv
dv/testbench.sv
